// File: hdl/pmct_pkg.sv
// ----------------------------------------------------------------------------
// pmct_pkg
// Shared types, header bit positions and the clamp function for the PS/2 mouse
// cursor tracker.
// ----------------------------------------------------------------------------
package pmct_pkg;

  localparam int unsigned COORD_W  = 12;
  localparam int unsigned CUR_W    = 4;
  localparam int unsigned BTN_W    = 3;
  localparam int unsigned DELTA_W  = 9;
  localparam int unsigned CFG_DATA_W = 12;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_PTR_W = 1;
  localparam int unsigned QUEUE_CNT_W = 2;

  // Header byte bit positions
  localparam int unsigned HDR_SYNC_BIT  = 3;
  localparam int unsigned HDR_X_SIGN    = 4;
  localparam int unsigned HDR_Y_SIGN    = 5;
  localparam int unsigned HDR_X_OVF     = 6;
  localparam int unsigned HDR_Y_OVF     = 7;

  // Register reset values
  localparam logic [COORD_W-1:0] SCREEN_WIDTH_RST  = 12'd640;
  localparam logic [COORD_W-1:0] SCREEN_HEIGHT_RST = 12'd480;
  localparam logic [CUR_W-1:0]   CURSOR_WIDTH_RST  = 4'd10;
  localparam logic [CUR_W-1:0]   CURSOR_HEIGHT_RST = 4'd13;

  typedef enum logic [1:0] {
    CFG_SCREEN_WIDTH  = 2'd0,
    CFG_SCREEN_HEIGHT = 2'd1,
    CFG_CURSOR_WIDTH  = 2'd2,
    CFG_CURSOR_HEIGHT = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_XDELTA = 2'd1,
    PH_YDELTA = 2'd2
  } phase_t;

  typedef struct packed {
    logic [COORD_W-1:0] screen_width;
    logic [COORD_W-1:0] screen_height;
    logic [CUR_W-1:0]   cursor_width;
    logic [CUR_W-1:0]   cursor_height;
  } cfg_t;

  // One decoded packet; deltas are raw 9-bit two's complement, Y not negated
  typedef struct packed {
    logic signed [DELTA_W-1:0] dx;
    logic signed [DELTA_W-1:0] dy;
    logic [BTN_W-1:0]          buttons;
  } pkt_t;

  // Move one axis by delta and clamp to 0..(screen - cursor), limit floored at 0
  function automatic logic [COORD_W-1:0] clamp_axis(
    input logic [COORD_W-1:0]   pos,
    input logic signed [DELTA_W:0] delta,
    input logic [COORD_W-1:0]   screen,
    input logic [CUR_W-1:0]     cur
  );
    logic signed [COORD_W+1:0] sum;
    logic signed [COORD_W:0]   lim;
    logic [COORD_W-1:0]        res;
    sum = $signed({2'b00, pos}) +
          $signed({{(COORD_W+1-DELTA_W){delta[DELTA_W]}}, delta});
    lim = $signed({1'b0, screen}) - $signed({{(COORD_W+1-CUR_W){1'b0}}, cur});
    if (lim < 0) begin
      lim = '0;
    end
    if (sum < 0) begin
      res = '0;
    end else if (sum > $signed({lim[COORD_W], lim})) begin
      res = lim[COORD_W-1:0];
    end else begin
      res = sum[COORD_W-1:0];
    end
    return res;
  endfunction

endpackage

// File: hdl/pmct_if.sv
// ----------------------------------------------------------------------------
// pmct_if
// Valid/ready channels for received mouse bytes and cursor results.
// ----------------------------------------------------------------------------
interface pmct_byte_if;
  import pmct_pkg::*;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface pmct_cursor_if;
  import pmct_pkg::*;
  logic               valid;
  logic               ready;
  logic [COORD_W-1:0] cursor_x;
  logic [COORD_W-1:0] cursor_y;
  logic [BTN_W-1:0]   button_bits;
  logic [BTN_W-1:0]   prior_button_bits;

  modport source (output valid, output cursor_x, output cursor_y,
                  output button_bits, output prior_button_bits, input ready);
  modport sink   (input valid, input cursor_x, input cursor_y,
                  input button_bits, input prior_button_bits, output ready);
endinterface

// File: hdl/pmct_front.sv
// ----------------------------------------------------------------------------
// pmct_front
// Packet assembler: resyncs on the header sync bit, collects three bytes,
// drops overflow packets and pushes decoded packets into the queue.
// ----------------------------------------------------------------------------
module pmct_front
  import pmct_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  pmct_byte_if.sink rx,
  output logic  push_valid,
  input  logic  push_ready,
  output pkt_t  push_pkt
);

  phase_t     byte_phase;
  phase_t     byte_phase_next;
  logic [7:0] header_byte;
  logic [7:0] x_delta_byte;
  logic       beat;

  // Accept a byte whenever the queue has room
  assign rx.ready = push_ready;
  assign beat     = rx.valid && rx.ready;

  // Hold phase
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_phase <= PH_HEADER;
    end else begin
      byte_phase <= byte_phase_next;
    end
  end

  // Capture header and X delta bytes
  always_ff @(posedge clk) begin
    if (beat && byte_phase == PH_XDELTA) begin
      x_delta_byte <= rx.rx_byte;
    end
    if (beat && byte_phase != PH_XDELTA && byte_phase != PH_YDELTA) begin
      header_byte <= rx.rx_byte;
    end
  end

  // Advance phase and form the packet on the Y byte
  always_comb begin
    byte_phase_next  = byte_phase;
    push_valid       = 1'b0;
    push_pkt.dx      = $signed({header_byte[HDR_X_SIGN], x_delta_byte});
    push_pkt.dy      = $signed({header_byte[HDR_Y_SIGN], rx.rx_byte});
    push_pkt.buttons = header_byte[BTN_W-1:0];
    if (beat) begin
      unique case (byte_phase)
        PH_XDELTA: byte_phase_next = PH_YDELTA;
        PH_YDELTA: begin
          byte_phase_next = PH_HEADER;
          push_valid      = !(header_byte[HDR_X_OVF] || header_byte[HDR_Y_OVF]);
        end
        default: begin
          byte_phase_next = rx.rx_byte[HDR_SYNC_BIT] ? PH_XDELTA : PH_HEADER;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_resync_hold: assert property (@(posedge clk) disable iff (rst)
    (beat && byte_phase == PH_HEADER && !rx.rx_byte[HDR_SYNC_BIT])
      |=> byte_phase == PH_HEADER)
    else $error("front left header phase on a byte without sync bit");

  a_push_only_on_y: assert property (@(posedge clk) disable iff (rst)
    push_valid |-> (byte_phase == PH_YDELTA && !header_byte[HDR_X_OVF]
                    && !header_byte[HDR_Y_OVF]))
    else $error("front pushed a packet outside the Y byte or on overflow");
`endif

endmodule

// File: hdl/pmct_queue.sv
// ----------------------------------------------------------------------------
// pmct_queue
// Two-entry packet queue between the assembler and the cursor stage.
// ----------------------------------------------------------------------------
module pmct_queue
  import pmct_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  output logic push_ready,
  input  pkt_t push_pkt,
  output logic pop_valid,
  input  logic pop_ready,
  output pkt_t pop_pkt
);

  pkt_t                   entries [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr;
  logic [QUEUE_PTR_W-1:0] rd_ptr;
  logic [QUEUE_CNT_W-1:0] count;
  logic                   do_push;
  logic                   do_pop;

  assign push_ready = count != QUEUE_CNT_W'(QUEUE_DEPTH);
  assign pop_valid  = count != '0;
  assign pop_pkt    = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Write entry
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_pkt;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_count_track: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> count == QUEUE_CNT_W'($past(count) + QUEUE_CNT_W'($past(do_push))
                                        - QUEUE_CNT_W'($past(do_pop))))
    else $error("queue count does not follow pushes and pops");
`endif

endmodule

// File: hdl/pmct_back.sv
// ----------------------------------------------------------------------------
// pmct_back
// Cursor stage: applies a packet's deltas to the kept position, clamps it
// and holds the result in the output register.
// ----------------------------------------------------------------------------
module pmct_back
  import pmct_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  cfg_t cfg,
  input  logic pop_valid,
  output logic pop_ready,
  input  pkt_t pop_pkt,
  pmct_cursor_if.source cursor
);

  logic [COORD_W-1:0]       position_x;
  logic [COORD_W-1:0]       position_y;
  logic [BTN_W-1:0]         held_buttons;
  logic [BTN_W-1:0]         earlier_buttons;
  logic                     out_valid;
  logic                     take;
  logic signed [DELTA_W:0]  dx_ext;
  logic signed [DELTA_W:0]  dy_neg;
  logic [COORD_W-1:0]       position_x_next;
  logic [COORD_W-1:0]       position_y_next;

  // Take a packet when the output register is empty or draining
  assign pop_ready = !out_valid || cursor.ready;
  assign take      = pop_valid && pop_ready;

  // Sign-extend X, negate Y so that down is positive
  assign dx_ext = $signed({pop_pkt.dx[DELTA_W-1], pop_pkt.dx});
  assign dy_neg = -$signed({pop_pkt.dy[DELTA_W-1], pop_pkt.dy});

  assign position_x_next = clamp_axis(position_x, dx_ext, cfg.screen_width,
                                      cfg.cursor_width);
  assign position_y_next = clamp_axis(position_y, dy_neg, cfg.screen_height,
                                      cfg.cursor_height);

  // Update position, buttons and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      position_x      <= '0;
      position_y      <= '0;
      held_buttons    <= '0;
      earlier_buttons <= '0;
      out_valid       <= 1'b0;
    end else begin
      if (take) begin
        position_x      <= position_x_next;
        position_y      <= position_y_next;
        held_buttons    <= pop_pkt.buttons;
        earlier_buttons <= held_buttons;
        out_valid       <= 1'b1;
      end else if (cursor.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign cursor.valid             = out_valid;
  assign cursor.cursor_x          = position_x;
  assign cursor.cursor_y          = position_y;
  assign cursor.button_bits       = held_buttons;
  assign cursor.prior_button_bits = earlier_buttons;

`ifndef SYNTHESIS
  a_take_loads: assert property (@(posedge clk) disable iff (rst)
    take |=> (out_valid && held_buttons == $past(pop_pkt.buttons)
              && earlier_buttons == $past(held_buttons)))
    else $error("cursor stage did not load the taken packet");

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !cursor.ready) |-> !take)
    else $error("cursor stage overwrote a waiting result");
`endif

endmodule

// File: hdl/ps2_mouse_packet_cursor_tracker_core.sv
// ----------------------------------------------------------------------------
// ps2_mouse_packet_cursor_tracker_core
// PS/2 mouse packet decoder with a clamped cursor position.
// ----------------------------------------------------------------------------
// Takes one mouse byte per cycle while the queue has room. The assembler
// resyncs on the header sync bit, gathers header, X and Y bytes, drops
// overflow packets and queues the rest in a two-entry queue; the cursor
// stage moves and clamps the position combinationally and holds the result
// in an output register; a packet passes from the queue entry to the output
// register. Sustained rate is one byte per cycle while results are taken.
// Position resets to 0,0; the user must write screen and cursor sizes
// through the register port while the block is idle, which the block
// itself leaves to the user.
module ps2_mouse_packet_cursor_tracker_core
  import pmct_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  logic [1:0]            cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  pmct_byte_if.sink             rx,
  pmct_cursor_if.source         cursor
);

  cfg_t cfg;
  logic push_valid;
  logic push_ready;
  pkt_t push_pkt;
  logic pop_valid;
  logic pop_ready;
  pkt_t pop_pkt;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.screen_width  <= SCREEN_WIDTH_RST;
      cfg.screen_height <= SCREEN_HEIGHT_RST;
      cfg.cursor_width  <= CURSOR_WIDTH_RST;
      cfg.cursor_height <= CURSOR_HEIGHT_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_SCREEN_WIDTH:  cfg.screen_width  <= cfg_data;
        CFG_SCREEN_HEIGHT: cfg.screen_height <= cfg_data;
        CFG_CURSOR_WIDTH:  cfg.cursor_width  <= cfg_data[CUR_W-1:0];
        CFG_CURSOR_HEIGHT: cfg.cursor_height <= cfg_data[CUR_W-1:0];
        default: ;
      endcase
    end
  end

  pmct_front u_front (
    .clk        (clk),
    .rst        (rst),
    .rx         (rx),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_pkt   (push_pkt)
  );

  pmct_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_pkt   (push_pkt),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_pkt    (pop_pkt)
  );

  pmct_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_pkt   (pop_pkt),
    .cursor    (cursor)
  );

endmodule

// File: tb/pmct_cursor_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmct_cursor_checker
// Watches the mouse byte and cursor channels of the PS/2 cursor tracker. It
// keeps its own packet assembler, cursor position and size registers, queues
// the cursor report each packet should cause, and compares every cursor beat
// field by field against the oldest queued report.
// ----------------------------------------------------------------------------
module pmct_cursor_checker
  import pmct_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  logic [1:0]            cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  pmct_byte_if                  mouse_bytes,
  pmct_cursor_if                cursor_out,
  output int                    fail_count,
  output int                    outstanding
);

  typedef struct {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [BTN_W-1:0]   buttons;
    logic [BTN_W-1:0]   prior;
  } cursor_report_t;

  cursor_report_t queued_reports[$];
  int             mismatches = 0;

  // Size registers as the block should hold them
  logic [COORD_W-1:0] scr_w, scr_h;
  logic [CUR_W-1:0]   cur_w, cur_h;

  // Packet assembly and cursor state
  phase_t             phase;
  logic [7:0]         hdr;
  logic [7:0]         x_raw;
  logic [COORD_W-1:0] pos_x, pos_y;
  logic [BTN_W-1:0]   btn_now, btn_prev;

  assign fail_count = mismatches;

  // Move one axis and keep it within 0..(screen - cursor), limit floored at 0
  function automatic logic [COORD_W-1:0] move_clamped(
    input logic [COORD_W-1:0] pos,
    input int                 delta,
    input logic [COORD_W-1:0] screen,
    input logic [CUR_W-1:0]   cur
  );
    int spot;
    int upper;
    spot  = int'(pos) + delta;
    upper = int'(screen) - int'(cur);
    if (upper < 0) upper = 0;
    if (spot < 0) spot = 0;
    if (spot > upper) spot = upper;
    return spot[COORD_W-1:0];
  endfunction

  // Feed one received byte through the assembler; queue a report on a good packet
  task automatic absorb_mouse_byte(input logic [7:0] b);
    int dx;
    int dy;
    cursor_report_t rep;
    case (phase)
      PH_XDELTA: begin
        x_raw = b;
        phase = PH_YDELTA;
      end
      PH_YDELTA: begin
        phase = PH_HEADER;
        if (!(hdr[HDR_X_OVF] || hdr[HDR_Y_OVF])) begin
          dx = int'(x_raw) - (hdr[HDR_X_SIGN] ? 256 : 0);
          dy = -(int'(b) - (hdr[HDR_Y_SIGN] ? 256 : 0));
          btn_prev = btn_now;
          btn_now  = hdr[BTN_W-1:0];
          pos_x    = move_clamped(pos_x, dx, scr_w, cur_w);
          pos_y    = move_clamped(pos_y, dy, scr_h, cur_h);
          rep.x       = pos_x;
          rep.y       = pos_y;
          rep.buttons = btn_now;
          rep.prior   = btn_prev;
          queued_reports.push_back(rep);
        end
      end
      default: begin
        // Hunt for a header: drop bytes without the sync bit
        phase = PH_HEADER;
        if (b[HDR_SYNC_BIT]) begin
          hdr   = b;
          phase = PH_XDELTA;
        end
      end
    endcase
  endtask

  // Compare one cursor beat with the oldest queued report
  task automatic check_cursor_beat();
    cursor_report_t want;
    if (queued_reports.size() == 0) begin
      $error("cursor beat with no report pending: x %0d y %0d buttons %0d prior %0d",
             cursor_out.cursor_x, cursor_out.cursor_y, cursor_out.button_bits,
             cursor_out.prior_button_bits);
      mismatches++;
    end else begin
      want = queued_reports.pop_front();
      if (cursor_out.cursor_x !== want.x) begin
        $error("cursor_x: expected %0d, got %0d", want.x, cursor_out.cursor_x);
        mismatches++;
      end
      if (cursor_out.cursor_y !== want.y) begin
        $error("cursor_y: expected %0d, got %0d", want.y, cursor_out.cursor_y);
        mismatches++;
      end
      if (cursor_out.button_bits !== want.buttons) begin
        $error("button_bits: expected %0d, got %0d", want.buttons,
               cursor_out.button_bits);
        mismatches++;
      end
      if (cursor_out.prior_button_bits !== want.prior) begin
        $error("prior_button_bits: expected %0d, got %0d", want.prior,
               cursor_out.prior_button_bits);
        mismatches++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      scr_w    = SCREEN_WIDTH_RST;
      scr_h    = SCREEN_HEIGHT_RST;
      cur_w    = CURSOR_WIDTH_RST;
      cur_h    = CURSOR_HEIGHT_RST;
      phase    = PH_HEADER;
      hdr      = '0;
      x_raw    = '0;
      pos_x    = '0;
      pos_y    = '0;
      btn_now  = '0;
      btn_prev = '0;
      queued_reports.delete();
    end else begin
      // Track register writes
      if (cfg_wr_en) begin
        case (cfg_reg_t'(cfg_index))
          CFG_SCREEN_WIDTH:  scr_w = cfg_data[COORD_W-1:0];
          CFG_SCREEN_HEIGHT: scr_h = cfg_data[COORD_W-1:0];
          CFG_CURSOR_WIDTH:  cur_w = cfg_data[CUR_W-1:0];
          CFG_CURSOR_HEIGHT: cur_h = cfg_data[CUR_W-1:0];
          default: ;
        endcase
      end
      if (mouse_bytes.valid && mouse_bytes.ready) begin
        absorb_mouse_byte(mouse_bytes.rx_byte);
      end
      if (cursor_out.valid && cursor_out.ready) begin
        check_cursor_beat();
      end
    end
    outstanding <= queued_reports.size();
  end

endmodule

// File: tb/ps2_mouse_packet_cursor_tracker_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ps2_mouse_packet_cursor_tracker_core_test
// Drives mouse bytes into the cursor tracker: a short directed run of edge
// deltas, dropped headers and overflow packets, then random packets with
// noise over six size settings, under random stalls on both sides and a long
// cursor-side stall. A checker beside the block predicts and compares every cursor beat.
// ----------------------------------------------------------------------------
module ps2_mouse_packet_cursor_tracker_core_test;
  import pmct_pkg::*;

  localparam int PHASE_ITEMS     = 78;
  localparam int HOLD_OFF_CYCLES = 200;
  localparam int SETTLE_CYCLES   = 6;
  localparam int QUIET_LIMIT     = 3000;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_wr_en;
  logic [1:0]            cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int send_idle_pct = 13;
  int recv_idle_pct = 79;
  int hold_off_req  = 0;
  int quiet_cycles  = 0;
  int fail_count;
  int outstanding;

  pmct_byte_if   mouse_bytes ();
  pmct_cursor_if cursor_out ();

  ps2_mouse_packet_cursor_tracker_core dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .rx        (mouse_bytes),
    .cursor    (cursor_out)
  );

  pmct_cursor_checker checker_i (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .mouse_bytes (mouse_bytes),
    .cursor_out  (cursor_out),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  always #4 clk = ~clk;

  // Cursor-side ready: random stalls, plus a long hold-off on request
  initial begin
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    cursor_out.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req != hold_seen) begin
        hold_seen = hold_off_req;
        hold_left = HOLD_OFF_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        cursor_out.ready <= 1'b0;
      end else begin
        cursor_out.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Count cycles with no beat on either channel
  always @(posedge clk) begin
    if ((mouse_bytes.valid && mouse_bytes.ready) || (cursor_out.valid && cursor_out.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("status: fail");
    $finish;
  end

  // Offer one byte, with a random gap first; valid stays high for the next beat
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      mouse_bytes.valid <= 1'b0;
      @(posedge clk);
    end
    mouse_bytes.valid   <= 1'b1;
    mouse_bytes.rx_byte <= b;
    do @(posedge clk); while (!mouse_bytes.ready);
  endtask

  task automatic send_packet(input logic [7:0] hdr, input logic [7:0] dx,
                             input logic [7:0] dy);
    send_byte(hdr);
    send_byte(dx);
    send_byte(dy);
  endtask

  // Well-formed header with random content; overflow bits left random on one in ten
  task automatic send_random_packet();
    logic [7:0] hdr;
    hdr = 8'($urandom);
    hdr[HDR_SYNC_BIT] = 1'b1;
    if ($urandom_range(9) != 0) begin
      hdr[HDR_X_OVF] = 1'b0;
      hdr[HDR_Y_OVF] = 1'b0;
    end
    send_packet(hdr, 8'($urandom), 8'($urandom));
  endtask

  // Stop offering bytes and hold until every report has come out
  task automatic drain();
    mouse_bytes.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write all four size registers back to back
  task automatic set_sizes(input logic [COORD_W-1:0] w, input logic [COORD_W-1:0] h,
                           input logic [CUR_W-1:0] cw, input logic [CUR_W-1:0] ch);
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_SCREEN_WIDTH;
    cfg_data  <= w;
    @(posedge clk);
    cfg_index <= CFG_SCREEN_HEIGHT;
    cfg_data  <= h;
    @(posedge clk);
    cfg_index <= CFG_CURSOR_WIDTH;
    cfg_data  <= CFG_DATA_W'(cw);
    @(posedge clk);
    cfg_index <= CFG_CURSOR_HEIGHT;
    cfg_data  <= CFG_DATA_W'(ch);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    int phase_items;
    rst                 <= 1'b1;
    cfg_wr_en           <= 1'b0;
    cfg_index           <= CFG_SCREEN_WIDTH;
    cfg_data            <= '0;
    mouse_bytes.valid   <= 1'b0;
    mouse_bytes.rx_byte <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: reset sizes, bytes dropped while hunting, edge deltas, overflow
    send_byte(8'h00);
    send_byte(8'hF7);
    send_packet(8'h0F, 8'hFF, 8'h00);
    send_packet(8'h38, 8'hFF, 8'h00);
    send_packet(8'h18, 8'h00, 8'hFF);
    send_packet(8'hC8, 8'h55, 8'hAA);
    send_packet(8'h4A, 8'h10, 8'h10);
    send_packet(8'h8D, 8'h10, 8'h10);
    send_packet(8'h0D, 8'hFF, 8'h80);
    send_packet(8'h0B, 8'hFF, 8'hFF);
    drain();

    // Random phases; the first third stalls mostly on the cursor side,
    // the middle mostly on the byte side, the last with no random stalls
    for (int ph = 0; ph < 6; ph++) begin
      if (ph < 2) begin
        send_idle_pct = 13;
        recv_idle_pct = 79;
      end else if (ph < 4) begin
        send_idle_pct = 79;
        recv_idle_pct = 13;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end

      case (ph)
        0: set_sizes(12'd4095, 12'd4095, 4'd0, 4'd1);
        1: set_sizes(12'd16, 12'd16, 4'd15, 4'd15);
        // Screen narrower than the cursor pins X at 0
        2: set_sizes(12'd12, 12'd300, 4'd15, 4'd7);
        3: set_sizes(COORD_W'($urandom_range(4095, 16)),
                     COORD_W'($urandom_range(4095, 16)),
                     CUR_W'($urandom_range(15, 1)), CUR_W'($urandom_range(15, 1)));
        4: set_sizes(12'd640, 12'd480, 4'd10, 4'd13);
        default: set_sizes(COORD_W'($urandom_range(64, 16)),
                           COORD_W'($urandom_range(64, 16)),
                           CUR_W'($urandom_range(15, 1)),
                           CUR_W'($urandom_range(15, 1)));
      endcase

      // Fill the block against a stalled cursor side, then wait it out
      if (ph == 4) begin
        hold_off_req++;
        repeat (12) send_random_packet();
        drain();
      end

      phase_items = 0;
      while (phase_items < PHASE_ITEMS) begin
        if ($urandom_range(99) < 8) begin
          send_byte(8'($urandom));
        end else begin
          send_random_packet();
          phase_items += 3;
        end
      end
      drain();
    end

    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
